// ===== hdl/spe_pkg.sv =====
// spe_pkg: shared types and constants of the set partition enumerator
// used by spe_cell, spe_row and set_partition_enumerator_unit; no dependencies

package spe_pkg;

    localparam int NODES    = 16;                   // node cells in the row
    localparam int DIG_W    = $clog2(NODES);        // part digit of one node
    localparam int CNT_W    = $clog2(NODES + 1);    // part counts, node count
    localparam int MASK_W   = 16;                   // part_mask / part_bits
    localparam int IDX_W    = 4;                    // part_index
    localparam int OP_W     = 2;                    // opcode
    localparam int CFG_W    = 5;                    // node_count register
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = ((IDX_W + MASK_W + 7) / 8) * 8;
    localparam int M_USER_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_NEXT  = 2'd0,
        OP_FIRST = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADVANCE,
        ST_KEY,
        ST_LABEL,
        ST_SETTLE,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_ADVANCE,
        CELL_LOAD,
        CELL_KEY,
        CELL_LABEL
    } cell_op_t;

    // command broadcast to every cell
    typedef struct packed {
        cell_op_t               op;
        logic [DIG_W-1:0]       slot;       // load slot being written
        logic [NODES-1:0]       slot_en;    // slots taking part in a relabel
        logic [DIG_W-1:0]       label;      // part number handed out this step
    } cell_cmd_t;

    // per-cell control from the row
    typedef struct packed {
        logic active;       // node below node_count
        logic mask_bit;     // this node's bit of the loaded mask
        logic inc_sel;      // digit that steps on advance
        logic zero_sel;     // digit above the stepping one
        logic leader;       // lowest unlabeled node
    } cell_ctl_t;

    // last load slot holding a node
    typedef struct packed {
        logic             found;
        logic [DIG_W-1:0] slot;
    } cell_key_t;

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic [CNT_W-1:0] pmax;     // parts used by this node and all below
        cell_key_t        key;
        logic             undone;
    } cell_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0] total;    // parts in the partition
        logic             busy;     // relabel still has unlabeled nodes
        logic [NODES-1:0] hits;     // nodes in the selected part
    } row_stat_t;

endpackage

// ===== hdl/spe_cell.sv =====
// spe_cell: one node of the enumerator row, holds its part digit, running
// part count, loaded mask column and relabel key; depends on spe_pkg

module spe_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spe_pkg::cell_cmd_t           cmd,
    input  spe_pkg::cell_ctl_t           ctl,
    input  spe_pkg::cell_key_t           bcast,
    input  logic [spe_pkg::CNT_W-1:0]    pmax_in,
    output spe_pkg::cell_stat_t          stat
);
    import spe_pkg::*;

    logic [DIG_W-1:0] digit_reg,  digit_next;
    logic [CNT_W-1:0] pmax_reg,   pmax_next;
    logic [NODES-1:0] col_reg,    col_next;
    cell_key_t        key_reg,    key_next;
    logic             undone_reg, undone_next;

    logic [NODES-1:0] col_hits;
    cell_key_t        key_calc;
    logic [CNT_W-1:0] own_count;

    // highest enabled slot whose mask holds this node
    always_comb begin
        col_hits       = col_reg & cmd.slot_en;
        key_calc.found = |col_hits;
        key_calc.slot  = '0;
        for (int s = 0; s < NODES; s++) begin
            if (col_hits[s]) begin
                key_calc.slot = DIG_W'(s);
            end
        end
    end

    // running part count moves one cell per cycle
    always_comb begin
        own_count = CNT_W'(digit_reg) + 1'b1;
        pmax_next = (pmax_in > own_count) ? pmax_in : own_count;
    end

    always_comb begin
        digit_next  = digit_reg;
        col_next    = col_reg;
        key_next    = key_reg;
        undone_next = undone_reg;
        case (cmd.op)
            CELL_CLEAR: begin
                digit_next = '0;
            end
            CELL_ADVANCE: begin
                if (ctl.inc_sel) begin
                    digit_next = digit_reg + 1'b1;
                end else if (ctl.zero_sel) begin
                    digit_next = '0;
                end
            end
            CELL_LOAD: begin
                col_next[cmd.slot] = ctl.mask_bit;
            end
            CELL_KEY: begin
                key_next    = key_calc;
                undone_next = ctl.active;
                if (!ctl.active) begin
                    digit_next = '0;
                end
            end
            CELL_LABEL: begin
                if (undone_reg && (ctl.leader || (bcast.found && key_reg.found &&
                                                  bcast.slot == key_reg.slot))) begin
                    digit_next  = cmd.label;
                    undone_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg  <= '0;
            pmax_reg   <= CNT_W'(1);
            undone_reg <= 1'b0;
        end else begin
            digit_reg  <= digit_next;
            pmax_reg   <= pmax_next;
            undone_reg <= undone_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
        key_reg <= key_next;
    end

    assign stat.digit  = digit_reg;
    assign stat.pmax   = pmax_reg;
    assign stat.key    = key_reg;
    assign stat.undone = undone_reg;

endmodule

// ===== hdl/spe_row.sv =====
// spe_row: the chain of node cells with neighbor links for the running part
// count, plus the select and relabel vectors; depends on spe_pkg, spe_cell

module spe_row (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spe_pkg::cell_cmd_t           cmd,
    input  logic [spe_pkg::CNT_W-1:0]    nodes,
    input  logic [spe_pkg::MASK_W-1:0]   mask,
    input  logic [spe_pkg::DIG_W-1:0]    part,
    output spe_pkg::row_stat_t           stat
);
    import spe_pkg::*;

    cell_stat_t       cst [NODES];
    cell_ctl_t        ctl [NODES];
    logic [CNT_W-1:0] pin [NODES];
    cell_key_t        bcast;

    logic [NODES-1:0] active;
    logic [NODES-1:0] can_inc;
    logic [NODES-1:0] inc_sel;
    logic [NODES-1:0] zero_sel;
    logic [NODES-1:0] undone;
    logic [NODES-1:0] leader;
    logic [NODES-1:0] hits;

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        if (g == 0) begin : g_head
            // node 0 always sits in part 0
            assign pin[g]     = '0;
            assign can_inc[g] = 1'b0;
        end else begin : g_link
            assign pin[g]     = cst[g-1].pmax;
            assign can_inc[g] = active[g] && (CNT_W'(cst[g].digit) < cst[g-1].pmax);
        end

        spe_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .ctl     (ctl[g]),
            .bcast   (bcast),
            .pmax_in (pin[g]),
            .stat    (cst[g])
        );
    end

    always_comb begin
        for (int d = 0; d < NODES; d++) begin
            active[d] = CNT_W'(d) < nodes;
            undone[d] = cst[d].undone;
            hits[d]   = active[d] && (cst[d].digit == part);
        end
    end

    // highest node that can step, nodes above it return to part 0
    always_comb begin
        for (int d = 0; d < NODES; d++) begin
            inc_sel[d] = can_inc[d] & ~|(can_inc & ({NODES{1'b1}} << (d + 1)));
        end
        for (int d = 0; d < NODES; d++) begin
            zero_sel[d] = |(inc_sel & ~({NODES{1'b1}} << d));
            leader[d]   = undone[d] & ~|(undone & ~({NODES{1'b1}} << d));
        end
    end

    always_comb begin
        bcast = '0;
        for (int d = 0; d < NODES; d++) begin
            if (leader[d]) begin
                bcast = cst[d].key;
            end
        end
    end

    always_comb begin
        for (int d = 0; d < NODES; d++) begin
            ctl[d].active   = active[d];
            ctl[d].mask_bit = mask[d];
            ctl[d].inc_sel  = inc_sel[d];
            ctl[d].zero_sel = zero_sel[d];
            ctl[d].leader   = leader[d];
        end
    end

    assign stat.total = cst[NODES-1].pmax;
    assign stat.busy  = |undone;
    assign stat.hits  = hits;

endmodule

// ===== hdl/set_partition_enumerator_unit.sv =====
// set_partition_enumerator_unit: top level, stream ports, command sequencer
// and result register around the cell row; depends on spe_pkg, spe_row
//
// next and first show their first part once the digits are advanced or cleared and the
//   part count has settled (next on the final partition repeats that partition without
//   settling), then one part a cycle while m_tready holds; non-closing load part transactions
//   leave the sequencer idle, the closing one runs the key and relabel steps and the count ripple
// the running part count ripples one cell a cycle, so every digit change waits for it
//   to reach the top cell before parts go out or the next command is taken
// reset: synchronous active low, comes up on the one-part partition of 16
//   nodes with no clearing pass

module set_partition_enumerator_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command transactions
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spe_pkg::S_DATA_W-1:0]    s_tdata,    // [15:0] part_mask
    input  logic [spe_pkg::S_USER_W-1:0]    s_tuser,    // [1:0] opcode
    input  logic                            s_tlast,    // load_last
    // part transactions
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spe_pkg::M_DATA_W-1:0]    m_tdata,    // [3:0] part_index, [19:4] part_bits
    output logic [spe_pkg::M_USER_W-1:0]    m_tuser,    // [0] at_final
    output logic                            m_tlast,    // last_part
    // node_count register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spe_pkg::CFG_W-1:0]       cfg_wdata
);
    import spe_pkg::*;

    state_t           state_reg,     state_next;
    logic [CNT_W-1:0] nodes_reg,     nodes_next;      // clamped node count
    logic [CNT_W-1:0] load_slot_reg, load_slot_next;  // saturates at NODES
    logic [NODES-1:0] slot_en_reg,   slot_en_next;
    logic [CNT_W-1:0] settle_reg,    settle_next;
    logic [CNT_W-1:0] part_reg,      part_next;
    logic [DIG_W-1:0] label_reg,     label_next;
    logic             emit_reg,      emit_next;       // parts go out after settling

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic [MASK_W-1:0] out_bits_reg,  out_bits_next;
    logic              out_last_reg,  out_last_next;
    logic              out_final_reg, out_final_next;

    cell_cmd_t        cmd;
    row_stat_t        rstat;
    logic             in_acc;
    logic             cfg_acc;
    logic             at_final;
    logic             part_is_last;
    logic [CNT_W-1:0] slots;
    opcode_t          opcode;

    function automatic logic [CNT_W-1:0] clamp_nodes(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (CFG_W'(v) > CFG_W'(NODES)) begin
            r = CNT_W'(NODES);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    spe_row u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .nodes   (nodes_reg),
        .mask    (s_tdata[MASK_W-1:0]),
        .part    (part_reg[DIG_W-1:0]),
        .stat    (rstat)
    );

    // config has priority; both only while idle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign opcode    = opcode_t'(s_tuser);

    // all singletons once the part count reaches the node count
    assign at_final     = (rstat.total == nodes_reg);
    assign part_is_last = (part_reg == rstat.total - 1'b1);

    // slots taking part in the closing relabel of a load
    assign slots = (load_slot_reg < CNT_W'(NODES)) ? load_slot_reg + 1'b1 : CNT_W'(NODES);

    always_comb begin
        state_next     = state_reg;
        nodes_next     = nodes_reg;
        load_slot_next = load_slot_reg;
        slot_en_next   = slot_en_reg;
        settle_next    = settle_reg;
        part_next      = part_reg;
        label_next     = label_reg;
        emit_next      = emit_reg;

        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_bits_next  = out_bits_reg;
        out_last_next  = out_last_reg;
        out_final_next = out_final_reg;

        cmd.op      = CELL_HOLD;
        cmd.slot    = load_slot_reg[DIG_W-1:0];
        cmd.slot_en = slot_en_reg;
        cmd.label   = label_reg;

        // result register drains independently of the sequencer
        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cfg_acc) begin
                    // new node count restarts from the one-part partition
                    nodes_next     = clamp_nodes(cfg_wdata);
                    load_slot_next = '0;
                    emit_next      = 1'b0;
                    state_next     = ST_CLEAR;
                end else if (in_acc) begin
                    case (opcode)
                        OP_NEXT: begin
                            load_slot_next = '0;
                            state_next     = ST_ADVANCE;
                        end
                        OP_FIRST: begin
                            load_slot_next = '0;
                            emit_next      = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        OP_LOAD: begin
                            // masks past the last slot are dropped
                            if (load_slot_reg < CNT_W'(NODES)) begin
                                cmd.op = CELL_LOAD;
                            end
                            if (s_tlast) begin
                                for (int i = 0; i < NODES; i++) begin
                                    slot_en_next[i] = CNT_W'(i) < slots;
                                end
                                load_slot_next = '0;
                                state_next     = ST_KEY;
                            end else begin
                                load_slot_next = slots;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.op      = CELL_CLEAR;
                settle_next = '0;
                state_next  = ST_SETTLE;
            end
            ST_ADVANCE: begin
                if (at_final) begin
                    // end of enumeration: same partition again
                    part_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    cmd.op      = CELL_ADVANCE;
                    settle_next = '0;
                    emit_next   = 1'b1;
                    state_next  = ST_SETTLE;
                end
            end
            ST_KEY: begin
                cmd.op     = CELL_KEY;
                label_next = '0;
                state_next = ST_LABEL;
            end
            ST_LABEL: begin
                // each step numbers the lowest unlabeled node and its slot mates
                if (rstat.busy) begin
                    cmd.op     = CELL_LABEL;
                    label_next = label_reg + 1'b1;
                end else begin
                    settle_next = '0;
                    emit_next   = 1'b0;
                    state_next  = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                // wait for the part count to ripple to the top cell
                if (settle_reg == CNT_W'(NODES - 1)) begin
                    part_next  = '0;
                    state_next = emit_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    settle_next = settle_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_index_next = part_reg[IDX_W-1:0];
                    out_bits_next  = MASK_W'(rstat.hits);
                    out_last_next  = part_is_last;
                    out_final_next = at_final;
                    if (part_is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        part_next = part_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            nodes_reg     <= CNT_W'(NODES);
            load_slot_reg <= '0;
            settle_reg    <= '0;
            part_reg      <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            nodes_reg     <= nodes_next;
            load_slot_reg <= load_slot_next;
            settle_reg    <= settle_next;
            part_reg      <= part_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_en_reg   <= slot_en_next;
        label_reg     <= label_next;
        out_index_reg <= out_index_next;
        out_bits_reg  <= out_bits_next;
        out_last_reg  <= out_last_next;
        out_final_reg <= out_final_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - MASK_W - IDX_W){1'b0}}, out_bits_reg, out_index_reg};
    assign m_tuser  = out_final_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/spe_checker.sv =====
// spe_checker: port-level checks on the part transactions of the enumerator
// bound to set_partition_enumerator_unit; no package dependency

module spe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled part holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("part transaction changed while stalled");

    // parts of one partition follow back to back with rising index
    a_part_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[3:0] == 4'($past(m_tdata[3:0]) + 4'd1)))
        else $error("part index did not step after a non-final part");

    // no part is empty
    a_part_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:4] != 16'd0)
        else $error("empty part emitted");

    // node 0 always belongs to part 0
    a_node0_part0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:0] == 4'd0) |-> m_tdata[4])
        else $error("part 0 without node 0");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("part offered after reset");

endmodule

bind set_partition_enumerator_unit spe_checker u_spe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
